[src/owik_pkg.sv]
// owik_pkg: shared types and constants for the omni wheel inverse kinematics core
// no dependencies
`timescale 1ns / 1ps

package owik_pkg;

    localparam int TRIG_STAGES = 16;
    localparam int NST = (TRIG_STAGES > 24) ? 24 : TRIG_STAGES;
    localparam int LATENCY = NST + 5;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0] ANGLE_PI_3 = 32'd715827883;

    localparam logic signed [33:0] ATAN_TAB [24] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
        34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
        34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
        34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
        34'sd652, 34'sd326, 34'sd163, 34'sd81
    };

    localparam logic REG_ROBOT_RADIUS = 1'b0;
    localparam logic REG_INV_WHEEL_RADIUS = 1'b1;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
        logic [15:0]        heading;
    } t_cmd;

    typedef struct packed {
        logic signed [23:0] wheel_one;
        logic signed [23:0] wheel_two;
        logic signed [23:0] wheel_three;
    } t_wheels;

endpackage

[src/owik_cordic.sv]
// owik_cordic: pipelined rotation-mode cordic, one stage per register
// depends on owik_pkg
`timescale 1ns / 1ps

module owik_cordic (
    input  logic               i_clk,
    input  logic [31:0]        i_ang,
    output logic signed [33:0] o_sin,
    output logic signed [33:0] o_cos
);

    logic signed [33:0] r_x [owik_pkg::NST+1];
    logic signed [33:0] r_y [owik_pkg::NST+1];
    logic signed [33:0] r_z [owik_pkg::NST+1];
    logic               r_flip [owik_pkg::NST+1];

    logic [31:0] n_sum;
    logic        n_flip;
    logic [31:0] n_red;

    // half-turn reduction into the right half plane
    always_comb begin
        n_sum  = i_ang + 32'h4000_0000;
        n_flip = n_sum[31];
        n_red  = n_flip ? i_ang + 32'h8000_0000 : i_ang;
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= owik_pkg::CORDIC_GAIN;
        r_y[0]    <= '0;
        r_z[0]    <= {{2{n_red[31]}}, n_red};
        r_flip[0] <= n_flip;
    end

    for (genvar g = 0; g < owik_pkg::NST; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!r_z[g][33]) begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] - owik_pkg::ATAN_TAB[g];
            end else begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] + owik_pkg::ATAN_TAB[g];
            end
            r_flip[g+1] <= r_flip[g];
        end
    end

    assign o_sin = r_flip[owik_pkg::NST] ? -r_y[owik_pkg::NST] : r_y[owik_pkg::NST];
    assign o_cos = r_flip[owik_pkg::NST] ? -r_x[owik_pkg::NST] : r_x[owik_pkg::NST];

endmodule

[src/omni_wheel_inverse_kinematics_core.sv]
// results pass the cordic registers, then product, row sum, scale and output registers
// throughput: one command per cycle, set by the fully pipelined cordic and multiply path
// busy is always low; the receiver cannot stall, each result beat shows for one cycle
// reset: synchronous active low, clears valid bits and restores both config registers
// depends on owik_pkg and owik_cordic
`timescale 1ns / 1ps

module omni_wheel_inverse_kinematics_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  owik_pkg::t_cmd        i_cmd,
    output logic                  o_valid,
    output owik_pkg::t_wheels     o_wheels,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [15:0]           i_cfg_data
);

    localparam int N = owik_pkg::NST;

    logic [15:0] r_robot_radius;
    logic [15:0] r_inv_wheel_radius;

    logic               r_vld [N+5];
    logic signed [15:0] r_vx [N+1];
    logic signed [15:0] r_vy [N+1];
    logic signed [15:0] r_w  [N+1];

    logic [31:0]        n_ang [3];
    logic signed [33:0] n_sin [3];
    logic signed [33:0] n_cos [3];

    logic signed [49:0] r_ps [3];
    logic signed [49:0] r_pc [3];
    logic signed [32:0] r_rot;
    logic signed [29:0] r_t [3];
    logic signed [46:0] r_p [3];
    logic signed [23:0] r_out [3];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_robot_radius     <= 16'd10014;
            r_inv_wheel_radius <= 16'd8533;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                owik_pkg::REG_ROBOT_RADIUS:     r_robot_radius <= i_cfg_data;
                owik_pkg::REG_INV_WHEEL_RADIUS: r_inv_wheel_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ang[0] = {i_cmd.heading, 16'd0};
        n_ang[1] = owik_pkg::ANGLE_PI_3 - {i_cmd.heading, 16'd0};
        n_ang[2] = owik_pkg::ANGLE_PI_3 + {i_cmd.heading, 16'd0};
    end

    for (genvar k = 0; k < 3; k++) begin : g_trig
        owik_cordic u_cordic (
            .i_clk (i_clk),
            .i_ang (n_ang[k]),
            .o_sin (n_sin[k]),
            .o_cos (n_cos[k])
        );
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N + 5; j++) r_vld[j] <= 1'b0;
        end else begin
            r_vld[0] <= start && !busy;
            for (int j = 1; j < N + 5; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    // velocity delay matching the cordic
    always_ff @(posedge i_clk) begin
        r_vx[0] <= i_cmd.vel_x;
        r_vy[0] <= i_cmd.vel_y;
        r_w[0]  <= i_cmd.yaw_rate;
        for (int j = 1; j <= N; j++) begin
            r_vx[j] <= r_vx[j-1];
            r_vy[j] <= r_vy[j-1];
            r_w[j]  <= r_w[j-1];
        end
    end

    // products
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_ps[k] <= n_sin[k] * r_vx[N];
            r_pc[k] <= n_cos[k] * r_vy[N];
        end
        r_rot <= r_w[N] * $signed({1'b0, r_robot_radius});
    end

    for (genvar k = 0; k < 3; k++) begin : g_row
        logic signed [51:0] n_row;
        logic signed [51:0] n_rnd;
        logic signed [46:0] n_prd;
        logic signed [26:0] n_q;

        always_comb begin
            case (k)
                0: n_row = -{{2{r_ps[k][49]}}, r_ps[k]} + {{2{r_pc[k][49]}}, r_pc[k]};
                1: n_row = -{{2{r_ps[k][49]}}, r_ps[k]} - {{2{r_pc[k][49]}}, r_pc[k]};
                default: n_row = {{2{r_ps[k][49]}}, r_ps[k]} - {{2{r_pc[k][49]}}, r_pc[k]};
            endcase
            n_rnd = n_row + {{5{r_rot[32]}}, r_rot, 14'd0} + 52'sd2097152;
            n_prd = r_p[k] + 47'sd524288;
            n_q   = n_prd[46:20];
        end

        always_ff @(posedge i_clk) begin
            r_t[k] <= n_rnd[51:22];
            r_p[k] <= r_t[k] * $signed({1'b0, r_inv_wheel_radius});
            if (n_q > 27'sd8388607)
                r_out[k] <= 24'sd8388607;
            else if (n_q < -27'sd8388608)
                r_out[k] <= -24'sd8388608;
            else
                r_out[k] <= n_q[23:0];
        end
    end

    assign o_valid              = r_vld[N+4];
    assign o_wheels.wheel_one   = r_out[0];
    assign o_wheels.wheel_two   = r_out[1];
    assign o_wheels.wheel_three = r_out[2];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(owik_pkg::LATENCY) o_valid)
        else $error("accepted command gave no result beat");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##(owik_pkg::LATENCY) !o_valid)
        else $error("result beat without a command");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat straight after reset");

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for omni_wheel_inverse_kinematics_core
// predicts wheel speeds with a bit-true cordic model, checks each result beat in order
// depends on owik_pkg and the core
`timescale 1ns / 1ps

module tb_top;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    owik_pkg::t_cmd       i_cmd = '0;
    logic                 o_valid;
    owik_pkg::t_wheels    o_wheels;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_addr = owik_pkg::REG_ROBOT_RADIUS;
    logic [15:0]          i_cfg_data = '0;

    omni_wheel_inverse_kinematics_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_valid(o_valid), .o_wheels(o_wheels), .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    owik_pkg::t_cmd    cmd_q[$];
    owik_pkg::t_wheels wheels_q[$];
    int      fails = 0;
    int      send_idle_pct = 0;
    logic [15:0] radius_m = 16'd10014;
    logic [15:0] inv_r_m = 16'd8533;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void rotate(input logic [31:0] ang, output longint s, output longint c);
        logic   flip;
        longint x, y, z, nx;
        flip = ang[31] ^ ang[30];
        if (flip) ang = ang + 32'h8000_0000;
        x = longint'(owik_pkg::CORDIC_GAIN);
        y = 64'sd0;
        z = longint'($signed(ang));
        for (int i = 0; i < owik_pkg::NST; i++) begin
            if (z >= 0) begin
                nx = x - fshift(y, i);
                y = y + fshift(x, i);
                z = z - longint'(owik_pkg::ATAN_TAB[i]);
            end else begin
                nx = x + fshift(y, i);
                y = y - fshift(x, i);
                z = z + longint'(owik_pkg::ATAN_TAB[i]);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic logic [23:0] to_wheel(longint sum);
        longint t, r;
        t = fshift(sum + (64'sd1 <<< 21), 22);
        r = fshift(t * longint'(inv_r_m) + (64'sd1 <<< 19), 20);
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    function automatic owik_pkg::t_wheels wheel_speeds(owik_pkg::t_cmd c);
        longint vx, vy, rot, s0, c0, s1, c1, s2, c2;
        logic [31:0] th;
        owik_pkg::t_wheels w;
        vx = longint'(c.vel_x);
        vy = longint'(c.vel_y);
        th = {c.heading, 16'h0};
        rotate(th, s0, c0);
        rotate(owik_pkg::ANGLE_PI_3 - th, s1, c1);
        rotate(owik_pkg::ANGLE_PI_3 + th, s2, c2);
        rot = longint'(c.yaw_rate) * longint'(radius_m) * 16384;
        w.wheel_one = to_wheel(-s0 * vx + c0 * vy + rot);
        w.wheel_two = to_wheel(-s1 * vx - c1 * vy + rot);
        w.wheel_three = to_wheel(s2 * vx - c2 * vy + rot);
        return w;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && busy)) begin
            if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_cmd <= cmd_q[0];
                start <= 1'b1;
                wheels_q.push_back(wheel_speeds(cmd_q[0]));
                void'(cmd_q.pop_front());
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (wheels_q.size() == 0) begin
                $error("unexpected result beat");
                fails++;
            end else begin
                if (o_wheels.wheel_one !== wheels_q[0].wheel_one) begin
                    $error("wheel_one exp %0d got %0d", wheels_q[0].wheel_one, o_wheels.wheel_one);
                    fails++;
                end
                if (o_wheels.wheel_two !== wheels_q[0].wheel_two) begin
                    $error("wheel_two exp %0d got %0d", wheels_q[0].wheel_two, o_wheels.wheel_two);
                    fails++;
                end
                if (o_wheels.wheel_three !== wheels_q[0].wheel_three) begin
                    $error("wheel_three exp %0d got %0d", wheels_q[0].wheel_three,
                        o_wheels.wheel_three);
                    fails++;
                end
                void'(wheels_q.pop_front());
            end
        end
    end

    task automatic drain();
        while (cmd_q.size() > 0 || start || wheels_q.size() > 0) @(negedge i_clk);
        repeat (owik_pkg::LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        if (idx == owik_pkg::REG_ROBOT_RADIUS) radius_m = val;
        else inv_r_m = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic owik_pkg::t_cmd rand_cmd();
        owik_pkg::t_cmd c;
        c = {$urandom, $urandom};
        case ($urandom_range(3))
            0: c.vel_x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1: c.yaw_rate = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            2: c.heading = 16'({3'($urandom_range(7)), 13'h0} + 16'($urandom_range(2)) - 16'd1);
            default: ;
        endcase
        return c;
    endfunction

    task automatic rand_phase(int n);
        repeat (n) cmd_q.push_back(rand_cmd());
        drain();
    endtask

    initial begin
        owik_pkg::t_cmd c;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed beats at reset settings
        for (int h = 0; h < 8; h++) begin
            c.vel_x = 16'sh7fff;
            c.vel_y = 16'sh8000;
            c.yaw_rate = (h[0]) ? 16'sh7fff : 16'sh8000;
            c.heading = {h[2:0], 13'h0};
            cmd_q.push_back(c);
        end
        cmd_q.push_back('0);
        cmd_q.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'hffff});
        cmd_q.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'h3fff});
        cmd_q.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'h4000});
        cmd_q.push_back({16'sh1000, 16'sh0000, 16'sh0000, 16'hc000});
        cmd_q.push_back({16'sh0000, 16'sh1000, 16'sh0000, 16'hbfff});
        drain();
        write_reg(owik_pkg::REG_ROBOT_RADIUS, 16'hffff);
        write_reg(owik_pkg::REG_INV_WHEEL_RADIUS, 16'hffff);
        cmd_q.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'h1234});
        cmd_q.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'h9234});
        drain();
        write_reg(owik_pkg::REG_ROBOT_RADIUS, 16'h0000);
        write_reg(owik_pkg::REG_INV_WHEEL_RADIUS, 16'h0000);
        cmd_q.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'h5555});
        drain();
        // random phases with different settings and pacing
        send_idle_pct = 21;
        write_reg(owik_pkg::REG_ROBOT_RADIUS, 16'd10014);
        write_reg(owik_pkg::REG_INV_WHEEL_RADIUS, 16'd8533);
        rand_phase(350);
        send_idle_pct = 70;
        write_reg(owik_pkg::REG_ROBOT_RADIUS, 16'hffff);
        write_reg(owik_pkg::REG_INV_WHEEL_RADIUS, 16'hffff);
        rand_phase(350);
        send_idle_pct = 0;
        write_reg(owik_pkg::REG_ROBOT_RADIUS, 16'($urandom));
        write_reg(owik_pkg::REG_INV_WHEEL_RADIUS, 16'($urandom));
        rand_phase(350);
        write_reg(owik_pkg::REG_ROBOT_RADIUS, 16'h0000);
        write_reg(owik_pkg::REG_INV_WHEEL_RADIUS, 16'($urandom_range(255)));
        rand_phase(350);
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
